### rtl/mt_pkg.sv
// Shared types, constants and codes for the MT19937 word generator.
`timescale 1ns / 1ps

package mt_pkg;

    localparam int unsigned STATE_SIZE   = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned ADDR_W       = 10;
    localparam int unsigned WORD_W       = 32;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_addr LAST_ADDR = t_addr'(STATE_SIZE - 1);

    localparam t_word MATRIX_A  = 32'h9908_B0DF;
    localparam t_word INIT_MULT = 32'd1812433253;
    localparam t_word TEMPER_B  = 32'h9D2C_5680;
    localparam t_word TEMPER_C  = 32'hEFC6_0000;
    localparam t_word RESET_SEED = 32'd5489;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_PRIME,
        ST_READY
    } t_state;

    // Access bundle from the controller to the state memory
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        logic  re;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_ram_req;

endpackage

### rtl/mt_stream_if.sv
// Valid/ready stream interfaces for draw requests and generated words.
`timescale 1ns / 1ps

interface mt_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink   (input valid, input reseed, output ready);
endinterface

interface mt_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### rtl/mt19937_word_generator.sv
// Top level of the MT19937 word generator: control, seeding and output stage.
//
//  channel   dir  payload            beat taken when
//  i_req     in   reseed (1 bit)     i_req.valid & i_req.ready
//  o_word    out  value (32 bits)    o_word.valid & o_word.ready
//  cfg       in   seed (32 bits)     i_cfg_we
//
// Words come out back to back, one per cycle while the output is taken, since
// each draw twists its own state entry in place while the memory read ports
// prefetch the two entries the next draw needs.
// Seeding writes one entry per cycle through the seed multiplier, all 624
// entries, then primes the read ports. It runs after reset, with no beat
// taken, and before the draw of a reseed beat.
// The output register holds a word until taken; a new request is taken while
// the register is empty or being emptied, seeding is done and no reseed draw is pending.
`timescale 1ns / 1ps

module mt19937_word_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    mt_req_if.sink      i_req,
    mt_word_if.source   o_word
);
    import mt_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_addr    r_idx;
    t_addr    n_idx;
    t_addr    r_pos;
    t_addr    n_pos;
    t_word    r_seed;
    t_word    r_prev;
    t_word    n_prev;
    t_word    r_cur;
    t_word    n_cur;
    logic     r_pend;
    logic     n_pend;
    logic     r_out_valid;
    logic     n_out_valid;
    t_word    r_out_value;
    t_word    n_out_value;

    t_ram_req ram_req;
    t_word    rd_nxt;
    t_word    rd_far;
    t_word    new_word;
    t_word    tempered;

    logic     out_free;
    logic     in_accept;
    logic     draw_fire;
    t_word    fill_word;
    t_word    fill_mixed;
    t_addr    pos_p1;
    t_addr    addr_nxt;
    t_addr    addr_far;
    logic [ADDR_W:0] far_sum;

    mt_state_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rdata_a (rd_nxt),
        .o_rdata_b (rd_far)
    );

    mt_twist_unit u_twist (
        .i_cur      (r_cur),
        .i_nxt      (rd_nxt),
        .i_far      (rd_far),
        .o_new_word (new_word),
        .o_tempered (tempered)
    );

    // Handshake qualifiers
    assign out_free    = !r_out_valid || o_word.ready;
    assign i_req.ready = (r_state == ST_READY) && !r_pend && out_free;
    assign in_accept   = i_req.valid && i_req.ready;
    assign draw_fire   = (r_state == ST_READY) && out_free &&
                         (r_pend || (in_accept && !i_req.reseed));

    // Seed recurrence for the current fill entry
    assign fill_mixed = r_prev ^ (r_prev >> 30);
    assign fill_word  = (r_idx == '0) ? r_seed
                                      : INIT_MULT * fill_mixed + {22'b0, r_idx};

    // Prefetch addresses for the entry after the current position
    assign pos_p1   = (r_pos == LAST_ADDR) ? '0 : r_pos + 10'd1;
    assign addr_nxt = (pos_p1 == LAST_ADDR) ? '0 : pos_p1 + 10'd1;
    assign far_sum  = {1'b0, pos_p1} + (ADDR_W + 1)'(TWIST_OFFSET);
    assign addr_far = (far_sum >= (ADDR_W + 1)'(STATE_SIZE))
                    ? t_addr'(far_sum - (ADDR_W + 1)'(STATE_SIZE))
                    : far_sum[ADDR_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (r_idx == LAST_ADDR) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = ST_READY;
            end
            ST_READY: begin
                if (in_accept && i_req.reseed) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        ram_req     = '0;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !o_word.ready;
        n_out_value = r_out_value;
        unique case (r_state)
            ST_FILL: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_idx;
                ram_req.wdata = fill_word;
                n_prev        = fill_word;
                n_idx         = (r_idx == LAST_ADDR) ? '0 : r_idx + 10'd1;
                if (r_idx == '0) begin
                    n_cur = r_seed;
                end
            end
            ST_PRIME: begin
                ram_req.re      = 1'b1;
                ram_req.raddr_a = t_addr'(1);
                ram_req.raddr_b = t_addr'(TWIST_OFFSET);
                n_pos           = '0;
            end
            ST_READY: begin
                if (in_accept && i_req.reseed) begin
                    n_pend = 1'b1;
                    n_idx  = '0;
                end
                if (draw_fire) begin
                    ram_req.we      = 1'b1;
                    ram_req.waddr   = r_pos;
                    ram_req.wdata   = new_word;
                    ram_req.re      = 1'b1;
                    ram_req.raddr_a = addr_nxt;
                    ram_req.raddr_b = addr_far;
                    n_cur           = rd_nxt;
                    n_pos           = pos_p1;
                    n_pend          = 1'b0;
                    n_out_valid     = 1'b1;
                    n_out_value     = tempered;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_idx       <= '0;
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_seed      <= RESET_SEED;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pos       <= n_pos;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_out_value <= n_out_value;
    end

    assign o_word.valid = r_out_valid;
    assign o_word.value = r_out_value;

`ifndef SYNTH
    // Draw position stays inside the state
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_ADDR)
        else $error("draw position out of range");

    // A draw leaves a word in the output register
    a_draw_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draw_fire |=> r_out_valid)
        else $error("draw produced no word");

    // A reseed beat restarts seeding from entry zero
    a_reseed_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req.reseed) |=> (r_state == ST_FILL) && (r_idx == '0) && r_pend)
        else $error("reseed did not restart seeding");

    // The far prefetch never targets the entry being written
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr_b))
        else $error("far read collides with write");

    // No word is dropped: a pending word is held while stalled
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_word.ready) |=> r_out_valid && $stable(r_out_value))
        else $error("stalled word lost");
`endif

endmodule

### rtl/mt_state_ram.sv
// State word memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module mt_state_ram (
    input  logic              i_clk,
    input  mt_pkg::t_ram_req  i_req,
    output mt_pkg::t_word     o_rdata_a,
    output mt_pkg::t_word     o_rdata_b
);
    import mt_pkg::*;

    t_word mem [STATE_SIZE];
    t_word r_rd_a;
    t_word r_rd_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read ports, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_a <= mem[i_req.raddr_a];
            r_rd_b <= mem[i_req.raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

### rtl/mt_twist_unit.sv
// Twist of one state entry and tempering of the new word.
`timescale 1ns / 1ps

module mt_twist_unit (
    input  mt_pkg::t_word i_cur,
    input  mt_pkg::t_word i_nxt,
    input  mt_pkg::t_word i_far,
    output mt_pkg::t_word o_new_word,
    output mt_pkg::t_word o_tempered
);
    import mt_pkg::*;

    t_word mix;
    t_word shifted;
    t_word new_word;
    t_word t1;
    t_word t2;
    t_word t3;

    // Combine high bit of this entry with low bits of the next
    assign mix      = {i_cur[31], i_nxt[30:0]};
    assign shifted  = (mix >> 1) ^ (mix[0] ? MATRIX_A : '0);
    assign new_word = i_far ^ shifted;

    // Temper
    assign t1 = new_word ^ (new_word >> 11);
    assign t2 = t1 ^ ((t1 << 7) & TEMPER_B);
    assign t3 = t2 ^ ((t2 << 15) & TEMPER_C);

    assign o_new_word = new_word;
    assign o_tempered = t3 ^ (t3 >> 18);

endmodule

### dv/tb_top.sv
// Self-checking testbench for the MT19937 word generator: directed table, then random beats.
`timescale 1ns / 1ps

module tb_top;
    import mt_pkg::*;

    localparam int unsigned PHASE_BEATS = 534;
    localparam int unsigned RESEED_PCT  = 2;
    localparam int unsigned N_ROWS      = 19;
    localparam t_word       UPPER_MASK  = 32'h8000_0000;
    localparam t_word       LOWER_MASK  = 32'h7FFF_FFFF;

    // Directed table rows: a draw request or a seed register write
    typedef enum logic {
        ROW_DRAW,
        ROW_SEED
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        logic      reseed;
        t_word     data;    // seed for ROW_SEED, known word for ROW_DRAW
        logic      known;
    } t_row;

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_word cfg_wdata;

    mt_req_if  req_if ();
    mt_word_if word_if ();

    // Shadow copy of the generator state
    t_word       mt_words [STATE_SIZE];
    int unsigned mt_pos;
    t_word       mt_seed;

    t_word       pending_words [$];
    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Outputs after reset and after seeds 1 and 0 are the well-known sequence starts
    t_row directed_rows [N_ROWS] = '{
        '{ROW_DRAW, 1'b0, 32'd3499211612, 1'b1},
        '{ROW_DRAW, 1'b0, 32'd581869302,  1'b1},
        '{ROW_DRAW, 1'b0, 32'd3890346734, 1'b1},
        '{ROW_DRAW, 1'b0, 32'd3586334585, 1'b1},
        '{ROW_DRAW, 1'b0, 32'd545404204,  1'b1},
        '{ROW_DRAW, 1'b1, 32'd3499211612, 1'b1},
        '{ROW_DRAW, 1'b0, 32'd581869302,  1'b1},
        // a seed write alone leaves the running sequence alone
        '{ROW_SEED, 1'b0, 32'h0000_0001,  1'b0},
        '{ROW_DRAW, 1'b0, 32'd3890346734, 1'b1},
        '{ROW_DRAW, 1'b1, 32'd1791095845, 1'b1},
        '{ROW_DRAW, 1'b0, 32'd4282876139, 1'b1},
        '{ROW_SEED, 1'b0, 32'h0000_0000,  1'b0},
        '{ROW_DRAW, 1'b1, 32'd2357136044, 1'b1},
        '{ROW_DRAW, 1'b0, 32'h0000_0000,  1'b0},
        '{ROW_SEED, 1'b0, 32'hFFFF_FFFF,  1'b0},
        '{ROW_DRAW, 1'b1, 32'h0000_0000,  1'b0},
        '{ROW_DRAW, 1'b0, 32'h0000_0000,  1'b0},
        // back-to-back reseeds
        '{ROW_DRAW, 1'b1, 32'h0000_0000,  1'b0},
        '{ROW_DRAW, 1'b1, 32'h0000_0000,  1'b0}
    };

    mt19937_word_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_word      (word_if)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("mt19937_word_generator test failed");
        $finish;
    end

    // Rebuild the state from the seed and force a twist on the next draw
    function automatic void fill_mt_state();
        t_word prev;
        mt_words[0] = mt_seed;
        for (int unsigned k = 1; k < STATE_SIZE; k++) begin
            prev = mt_words[k-1];
            mt_words[k] = INIT_MULT * (prev ^ (prev >> 30)) + k;
        end
        mt_pos = STATE_SIZE;
    endfunction

    // Regenerate all entries in place
    function automatic void twist_mt_state();
        t_word mix;
        t_word shifted;
        for (int unsigned k = 0; k < STATE_SIZE; k++) begin
            mix = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % STATE_SIZE] & LOWER_MASK);
            shifted = mix >> 1;
            if (mix[0]) begin
                shifted = shifted ^ MATRIX_A;
            end
            mt_words[k] = mt_words[(k + TWIST_OFFSET) % STATE_SIZE] ^ shifted;
        end
        mt_pos = 0;
    endfunction

    function automatic t_word temper_word(t_word raw);
        t_word w;
        w = raw;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & TEMPER_B);
        w = w ^ ((w << 15) & TEMPER_C);
        w = w ^ (w >> 18);
        return w;
    endfunction

    // Advance the shadow state by one request and return the word it yields
    function automatic t_word next_mt_word(logic reseed);
        t_word w;
        if (reseed) begin
            fill_mt_state();
        end
        if (mt_pos >= STATE_SIZE) begin
            twist_mt_state();
        end
        w = temper_word(mt_words[mt_pos]);
        mt_pos++;
        return w;
    endfunction

    // Drive one request beat after a random gap; queue its word once taken
    task automatic send_req(input logic reseed, input logic known, input t_word known_word);
        t_word want;
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) begin
                @(posedge clk);
            end
        end
        req_if.valid  <= 1'b1;
        req_if.reseed <= reseed;
        @(posedge clk);
        while (!(req_if.valid && req_if.ready)) begin
            @(posedge clk);
        end
        want = next_mt_word(reseed);
        pending_words.push_back(known ? known_word : want);
    endtask

    // Drain all words, then write the seed register
    task automatic write_seed(input t_word value);
        req_if.valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        mt_seed = value;
    endtask

    // Check each word beat against the oldest expectation; randomize ready
    always @(posedge clk) begin : word_check
        t_word want;
        if (rst_n && word_if.valid && word_if.ready) begin
            if (pending_words.size() == 0) begin
                $error("value: expected none, actual %08h", word_if.value);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                if (word_if.value !== want) begin
                    $error("value: expected %08h, actual %08h", want, word_if.value);
                    fail_count++;
                end
            end
        end
        word_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin : stimulus
        t_row row;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_if.valid   = 1'b0;
        req_if.reseed  = 1'b0;
        word_if.ready  = 1'b0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        mt_seed        = RESET_SEED;
        fill_mt_state();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int unsigned r = 0; r < N_ROWS; r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_SEED) begin
                write_seed(row.data);
            end else begin
                send_req(row.reseed, row.known, row.data);
            end
        end

        // Random phases: busy sink, then slow sender, then full rate
        for (int unsigned p = 0; p < 3; p++) begin
            write_seed($urandom);
            case (p)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int unsigned i = 0; i < PHASE_BEATS; i++) begin
                if (i % 180 == 179) begin
                    write_seed($urandom);
                end
                send_req($urandom_range(99) < RESEED_PCT, 1'b0, '0);
            end
        end

        // Drain, then allow the output stage to settle
        req_if.valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        if (fail_count == 0) begin
            $display("mt19937_word_generator test passed");
        end else begin
            $display("mt19937_word_generator test failed");
        end
        $finish;
    end

endmodule
